### rtl/content_store_replacement_unit_defines.svh
// ----------------------------------------------------------------------------
// Content store replacement unit: assertion macros
// Shared concurrent assertion macros, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONTENT_STORE_REPLACEMENT_UNIT_DEFINES_SVH
`define CONTENT_STORE_REPLACEMENT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define CSRU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define CSRU_ASSERT_NEVER(lbl, expr, msg) \
    `CSRU_ASSERT(lbl, !(expr), msg)
`else
`define CSRU_ASSERT(lbl, prop, msg)
`define CSRU_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

### rtl/csru_pkg.sv
// ----------------------------------------------------------------------------
// Content store replacement unit: package
// Types, constants and command structures shared by the unit's modules.
// ----------------------------------------------------------------------------
package csru_pkg;

    localparam int ENTRIES     = 64;
    localparam int SIZE_BITS   = 16;
    localparam int KEY_W       = 32;
    localparam int TIME_W      = 32;
    localparam int USE_W       = 16;
    localparam int BYTES_W     = 22;
    localparam int COUNT_OUT_W = 7;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int POLICY_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 22;

    localparam logic [USE_W-1:0] USE_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;

    typedef enum logic [POLICY_W-1:0] {
        POL_FIFO   = 2'd0,
        POL_LFU    = 2'd1,
        POL_NEWEST = 2'd2,
        POL_TTL    = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        PASS_TTL   = 2'd0,
        PASS_MATCH = 2'd1,
        PASS_MIN   = 2'd2,
        PASS_DROP  = 2'd3
    } pass_mode_t;

    typedef enum logic [1:0] {
        POS_FIRST = 2'd0,
        POS_LAST  = 2'd1,
        POS_BEST  = 2'd2
    } pos_sel_t;

    typedef struct packed {
        logic [KEY_W-1:0]     name_key;
        logic [SIZE_BITS-1:0] payload_size;
        logic [TIME_W-1:0]    expiry_time;
        logic [TIME_W-1:0]    now_time;
    } item_t;

    typedef struct packed {
        logic [BYTES_W-1:0]     removed_bytes;
        logic [BYTES_W-1:0]     stored_bytes;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   table_full;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [SIZE_BITS-1:0] size;
        logic [TIME_W-1:0]    expiry;
        logic [USE_W-1:0]     uses;
    } entry_t;

    typedef struct packed {
        logic       load_item;
        logic       start;
        pass_mode_t mode;
        pos_sel_t   pos_sel;
        logic       advance;
        logic       finish;
        logic       insert;
        logic       emit;
    } dp_cmd_t;

    typedef struct packed {
        logic    busy;
        logic    evict_needed;
        logic    out_busy;
        policy_t policy;
    } dp_status_t;

endpackage

### rtl/csru_ram.sv
// ----------------------------------------------------------------------------
// Content store replacement unit: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module csru_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/csru_datapath.sv
// ----------------------------------------------------------------------------
// Content store replacement unit: datapath
// Entry memory, scan pointers, byte and entry counters, and the result register.
// ----------------------------------------------------------------------------
`include "content_store_replacement_unit_defines.svh"

module csru_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [csru_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csru_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  csru_pkg::item_t                      item,
    input  csru_pkg::dp_cmd_t                    cmd,
    output csru_pkg::dp_status_t                 status,
    output csru_pkg::result_t                    result,
    output logic                                 result_valid,
    input  logic                                 result_ready
);
    import csru_pkg::*;

    logic [POLICY_W-1:0] policy_reg;
    logic [BYTES_W-1:0]  cap_reg;
    item_t               item_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [BYTES_W-1:0]  bytes_reg;
    logic [BYTES_W-1:0]  removed_reg;
    logic                full_reg;
    logic [CNT_W-1:0]    rd_idx_reg;
    logic [CNT_W-1:0]    wr_idx_reg;
    logic                pend_reg;
    logic [IDX_W-1:0]    pend_idx_reg;
    pass_mode_t          mode_reg;
    logic [IDX_W-1:0]    pos_reg;
    logic                found_reg;
    logic                best_valid_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [USE_W-1:0]    best_cnt_reg;
    result_t             result_reg;
    logic                result_valid_reg;

    entry_t              rdata;
    entry_t              wdata;
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic                re;
    logic [IDX_W-1:0]    start_idx;
    logic                drop;
    logic [BYTES_W-1:0]  rd_size;
    logic [BYTES_W:0]    fit_sum;

    csru_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    assign re      = cmd.advance && (rd_idx_reg < n_reg);
    assign rd_size = BYTES_W'(rdata.size);
    assign fit_sum = {1'b0, bytes_reg} + (BYTES_W + 1)'(item_reg.payload_size);

    always_comb
    begin
        unique case (cmd.pos_sel)
            POS_FIRST: start_idx = '0;
            POS_LAST:  start_idx = IDX_W'(n_reg - 1'b1);
            POS_BEST:  start_idx = best_idx_reg;
            default:   start_idx = '0;
        endcase
        if (cmd.mode != PASS_DROP)
        begin
            start_idx = '0;
        end
    end

    always_comb
    begin
        drop = 1'b0;
        if (pend_reg)
        begin
            if (mode_reg == PASS_TTL)
            begin
                drop = (rdata.expiry <= item_reg.now_time);
            end
            else if (mode_reg == PASS_DROP)
            begin
                drop = (pend_idx_reg == pos_reg);
            end
        end
    end

    // Only one writer is active in any cycle: pass compaction, use-count bump or insert.
    always_comb
    begin
        we    = 1'b0;
        waddr = wr_idx_reg[IDX_W-1:0];
        wdata = rdata;
        if (cmd.insert)
        begin
            we    = (n_reg < CNT_W'(ENTRIES));
            waddr = n_reg[IDX_W-1:0];
            wdata = '{key:    item_reg.name_key,
                      size:   item_reg.payload_size,
                      expiry: item_reg.expiry_time,
                      uses:   '0};
        end
        else if (pend_reg)
        begin
            if ((mode_reg == PASS_TTL || mode_reg == PASS_DROP) && !drop)
            begin
                we = 1'b1;
            end
            else if (mode_reg == PASS_MATCH && !found_reg &&
                     rdata.key == item_reg.name_key && rdata.uses != USE_MAX)
            begin
                we         = 1'b1;
                waddr      = pend_idx_reg;
                wdata.uses = rdata.uses + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.emit)
        begin
            result_reg <= '{removed_bytes: removed_reg,
                            stored_bytes:  bytes_reg,
                            entry_count:   COUNT_OUT_W'(n_reg),
                            table_full:    full_reg};
        end
        if (cmd.advance)
        begin
            pend_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (cmd.start)
        begin
            pos_reg <= start_idx;
        end
        if (pend_reg && mode_reg == PASS_MIN && (!best_valid_reg || rdata.uses < best_cnt_reg))
        begin
            best_idx_reg <= pend_idx_reg;
            best_cnt_reg <= rdata.uses;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg       <= POL_FIFO;
            cap_reg          <= '0;
            n_reg            <= '0;
            bytes_reg        <= '0;
            removed_reg      <= '0;
            full_reg         <= 1'b0;
            rd_idx_reg       <= '0;
            wr_idx_reg       <= '0;
            pend_reg         <= 1'b0;
            mode_reg         <= PASS_TTL;
            found_reg        <= 1'b0;
            best_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POLICY:   policy_reg <= cfg_data[POLICY_W-1:0];
                    REG_CAPACITY: cap_reg    <= cfg_data[BYTES_W-1:0];
                    default:      ;
                endcase
            end

            if (cmd.load_item)
            begin
                removed_reg <= '0;
                full_reg    <= 1'b0;
            end

            if (cmd.start)
            begin
                rd_idx_reg     <= CNT_W'(start_idx);
                wr_idx_reg     <= CNT_W'(start_idx);
                pend_reg       <= 1'b0;
                mode_reg       <= cmd.mode;
                found_reg      <= 1'b0;
                best_valid_reg <= 1'b0;
            end
            else
            begin
                pend_reg <= re;
                if (re)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (drop)
                    begin
                        bytes_reg   <= bytes_reg - rd_size;
                        removed_reg <= removed_reg + rd_size;
                    end
                    else if (mode_reg == PASS_TTL || mode_reg == PASS_DROP)
                    begin
                        wr_idx_reg <= wr_idx_reg + 1'b1;
                    end
                    if (mode_reg == PASS_MATCH && rdata.key == item_reg.name_key)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (mode_reg == PASS_MIN)
                    begin
                        best_valid_reg <= 1'b1;
                    end
                end
            end

            if (cmd.finish && (mode_reg == PASS_TTL || mode_reg == PASS_DROP))
            begin
                n_reg <= wr_idx_reg;
            end

            if (cmd.insert)
            begin
                if (n_reg < CNT_W'(ENTRIES))
                begin
                    n_reg     <= n_reg + 1'b1;
                    bytes_reg <= bytes_reg + BYTES_W'(item_reg.payload_size);
                end
                else
                begin
                    full_reg <= 1'b1;
                end
            end

            if (cmd.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign status.busy         = (rd_idx_reg < n_reg) || pend_reg;
    assign status.evict_needed = (cap_reg != '0) && (n_reg != '0) &&
                                 (fit_sum > {1'b0, cap_reg});
    assign status.out_busy     = result_valid_reg && !result_ready;
    assign status.policy       = policy_t'(policy_reg);
    assign result              = result_reg;
    assign result_valid        = result_valid_reg;

    `CSRU_ASSERT(a_count_bound, (n_reg <= CNT_W'(ENTRIES)), "entry count above table size")
    `CSRU_ASSERT(a_wr_behind_rd, (wr_idx_reg <= rd_idx_reg), "compaction write pointer ahead of read")
    `CSRU_ASSERT(a_drop_one, ((cmd.finish && mode_reg == PASS_DROP) |-> (wr_idx_reg + 1'b1 == n_reg)), "single eviction did not remove exactly one entry")
    `CSRU_ASSERT_NEVER(a_pend_range, (pend_reg && CNT_W'(pend_idx_reg) >= n_reg), "read beyond held entries")

endmodule

### rtl/csru_ctrl.sv
// ----------------------------------------------------------------------------
// Content store replacement unit: controller
// Sequences the scan passes, eviction loop, insert and result hand-off.
// ----------------------------------------------------------------------------
module csru_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  csru_pkg::dp_status_t status,
    output csru_pkg::dp_cmd_t    cmd
);
    import csru_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_TTL    = 8'b0000_0010,
        S_MATCH  = 8'b0000_0100,
        S_CHECK  = 8'b0000_1000,
        S_MIN    = 8'b0001_0000,
        S_DROP   = 8'b0010_0000,
        S_INSERT = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mode   = PASS_TTL;
        cmd.pos_sel = POS_FIRST;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (status.policy == POL_TTL)
                    begin
                        cmd.start  = 1'b1;
                        cmd.mode   = PASS_TTL;
                        state_next = S_TTL;
                    end
                    else if (status.policy == POL_LFU)
                    begin
                        cmd.start  = 1'b1;
                        cmd.mode   = PASS_MATCH;
                        state_next = S_MATCH;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_TTL:
            begin
                cmd.advance = status.busy;
                if (!status.busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_INSERT;
                end
            end
            S_MATCH:
            begin
                cmd.advance = status.busy;
                if (!status.busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!status.evict_needed)
                begin
                    state_next = S_INSERT;
                end
                else if (status.policy == POL_LFU)
                begin
                    cmd.start  = 1'b1;
                    cmd.mode   = PASS_MIN;
                    state_next = S_MIN;
                end
                else
                begin
                    cmd.start   = 1'b1;
                    cmd.mode    = PASS_DROP;
                    cmd.pos_sel = (status.policy == POL_FIFO) ? POS_FIRST : POS_LAST;
                    state_next  = S_DROP;
                end
            end
            S_MIN:
            begin
                cmd.advance = status.busy;
                if (!status.busy)
                begin
                    cmd.finish  = 1'b1;
                    cmd.start   = 1'b1;
                    cmd.mode    = PASS_DROP;
                    cmd.pos_sel = POS_BEST;
                    state_next  = S_DROP;
                end
            end
            S_DROP:
            begin
                cmd.advance = status.busy;
                if (!status.busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/content_store_replacement_unit.sv
// FIFO and evict-newest with no eviction check the budget and insert. LFU adds a key-match
// scan over the n held entries. TTL runs an expiry scan over the n entries in place of the
// budget check. Each eviction compacts the entries from slot p down (LFU: after a scan for
// the least-used entry). The next transaction is accepted once the result is registered.
// Reset (rst_n, asynchronous, active low) empties the store, selects FIFO, unlimited budget.
// ----------------------------------------------------------------------------
// Content store replacement unit
// Byte-budgeted content store kept in insertion order with FIFO, LFU,
// evict-newest and expiry-based replacement.
// ----------------------------------------------------------------------------
module content_store_replacement_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [csru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csru_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  csru_pkg::item_t                 item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output csru_pkg::result_t               result
);
    import csru_pkg::*;

    // The controller and datapath talk only through these two structures.
    // Commands steer the scan pointers and counters; status reports whether
    // a scan still has entries in flight, whether the arriving transaction
    // still overflows the budget, and whether the result register is free.
    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller accepts a transaction only when idle. The result
    // register decouples the output side, so a finished result may wait
    // while the next transaction is already being processed.
    csru_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath holds the entries in one RAM in insertion order. Every
    // removal compacts the order by copying the following entries down one
    // slot at a time, one entry per cycle through the RAM's two ports.
    csru_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule
